FILE: rtl/hcbd_pkg.sv
package hcbd_pkg;

   // Widths of the chunk size counters and of the reported total.
   localparam int LENGTH_BITS = 32;
   localparam int TOTAL_BITS  = 32;
   localparam int SUM_BITS    = ((LENGTH_BITS > TOTAL_BITS) ? LENGTH_BITS : TOTAL_BITS) + 1;

   // Character codes used by the framing parser.
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_F  = 8'h66;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [3:0] HEX_TEN    = 4'd10;

   // One result item as it leaves the parser.
   typedef struct packed {
      logic [7:0]            payload_byte;
      logic                  payload_valid;
      logic                  message_done;
      logic                  framing_error;
      logic [TOTAL_BITS-1:0] body_length;
   } result_type;

endpackage

FILE: rtl/hcbd_parser.sv
module hcbd_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   chunked_mode,
   input  logic [7:0]             data_byte,
   output hcbd_pkg::result_type   res
);
   import hcbd_pkg::*;

   typedef enum logic [4:0] {
      PH_SIZE    = 5'b00001,
      PH_SIZE_LF = 5'b00010,
      PH_BYTES   = 5'b00100,
      PH_CR      = 5'b01000,
      PH_LF      = 5'b10000
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] chunk_size_ff, chunk_size_in;
   logic [LENGTH_BITS-1:0] bytes_in_chunk_ff, bytes_in_chunk_in;
   logic [TOTAL_BITS-1:0]  running_total_ff, running_total_in;
   logic                   have_digit_ff, have_digit_in;

   logic                   is_hex;
   logic [3:0]             hex_val;
   logic [SUM_BITS-1:0]    total_sum;
   logic [TOTAL_BITS-1:0]  total_sat;
   logic [LENGTH_BITS-1:0] bytes_next;
   logic                   err;

   // Hex digit decode of the incoming byte.
   always_comb begin
      is_hex  = 1'b1;
      hex_val = 4'd0;
      if (data_byte >= CHAR_0 && data_byte <= CHAR_9) begin
         hex_val = 4'(data_byte - CHAR_0);
      end else if (data_byte >= CHAR_LO_A && data_byte <= CHAR_LO_F) begin
         hex_val = 4'(data_byte - CHAR_LO_A) + HEX_TEN;
      end else if (data_byte >= CHAR_UP_A && data_byte <= CHAR_UP_F) begin
         hex_val = 4'(data_byte - CHAR_UP_A) + HEX_TEN;
      end else begin
         is_hex = 1'b0;
      end
   end

   // Saturating addition of the chunk size into the message total.
   assign total_sum  = SUM_BITS'(running_total_ff) + SUM_BITS'(chunk_size_ff);
   assign total_sat  = (total_sum[SUM_BITS-1:TOTAL_BITS] != '0) ? '1
                       : total_sum[TOTAL_BITS-1:0];
   assign bytes_next = bytes_in_chunk_ff + LENGTH_BITS'(1);

   // Framing state machine and the result of the current byte.
   always_comb begin
      phase_in          = phase_ff;
      chunk_size_in     = chunk_size_ff;
      bytes_in_chunk_in = bytes_in_chunk_ff;
      running_total_in  = running_total_ff;
      have_digit_in     = have_digit_ff;
      err               = 1'b0;
      res               = '0;

      if (!chunked_mode) begin
         res.payload_byte  = data_byte;
         res.payload_valid = 1'b1;
      end else begin
         case (phase_ff)
            PH_SIZE: begin
               if (is_hex) begin
                  if (chunk_size_ff[LENGTH_BITS-1 -: 4] != 4'd0) begin
                     err = 1'b1;
                  end else begin
                     chunk_size_in = {chunk_size_ff[LENGTH_BITS-5:0], hex_val};
                     have_digit_in = 1'b1;
                  end
               end else if (data_byte == CHAR_CR && have_digit_ff) begin
                  running_total_in = total_sat;
                  phase_in         = PH_SIZE_LF;
               end else begin
                  err = 1'b1;
               end
            end
            PH_SIZE_LF: begin
               if (data_byte == CHAR_LF) begin
                  bytes_in_chunk_in = '0;
                  phase_in = (chunk_size_ff == '0) ? PH_CR : PH_BYTES;
               end else begin
                  err = 1'b1;
               end
            end
            PH_BYTES: begin
               res.payload_byte  = data_byte;
               res.payload_valid = 1'b1;
               bytes_in_chunk_in = bytes_next;
               if (bytes_next >= chunk_size_ff) begin
                  phase_in = PH_CR;
               end
            end
            PH_CR: begin
               if (data_byte == CHAR_CR) begin
                  phase_in = PH_LF;
               end else begin
                  err = 1'b1;
               end
            end
            PH_LF: begin
               if (data_byte == CHAR_LF) begin
                  if (chunk_size_ff != '0) begin
                     chunk_size_in     = '0;
                     bytes_in_chunk_in = '0;
                     have_digit_in     = 1'b0;
                     phase_in          = PH_SIZE;
                  end else begin
                     res.message_done  = 1'b1;
                     res.body_length   = running_total_ff;
                     phase_in          = PH_SIZE;
                     chunk_size_in     = '0;
                     bytes_in_chunk_in = '0;
                     running_total_in  = '0;
                     have_digit_in     = 1'b0;
                  end
               end else begin
                  err = 1'b1;
               end
            end
            default: begin
               err = 1'b1;
            end
         endcase

         // A framing error drops the message and starts over.
         if (err) begin
            phase_in          = PH_SIZE;
            chunk_size_in     = '0;
            bytes_in_chunk_in = '0;
            running_total_in  = '0;
            have_digit_in     = 1'b0;
         end
         res.framing_error = err;
      end
   end

   // State registers advance only when a byte moves to the result stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_SIZE;
         chunk_size_ff     <= '0;
         bytes_in_chunk_ff <= '0;
         running_total_ff  <= '0;
         have_digit_ff     <= 1'b0;
      end else if (step) begin
         phase_ff          <= phase_in;
         chunk_size_ff     <= chunk_size_in;
         bytes_in_chunk_ff <= bytes_in_chunk_in;
         running_total_ff  <= running_total_in;
         have_digit_ff     <= have_digit_in;
      end
   end

`ifndef SYNTH
   // An error always leaves the parser waiting for a fresh size.
   a_err_restart: assert property (@(posedge clock) disable iff (reset)
      step && res.framing_error |=> phase_ff == PH_SIZE && chunk_size_ff == '0)
      else $error("parser did not restart after a framing error");

   // Done and error never come out for the same byte.
   a_done_err_excl: assert property (@(posedge clock) disable iff (reset)
      step |-> !(res.message_done && res.framing_error))
      else $error("message done and framing error together");

   // The total is cleared once the message has been reported.
   a_done_clears_total: assert property (@(posedge clock) disable iff (reset)
      step && res.message_done |=> running_total_ff == '0)
      else $error("total not cleared after message done");

   // While passing payload the count stays below a nonzero chunk size.
   a_bytes_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BYTES |-> chunk_size_ff != '0 && bytes_in_chunk_ff < chunk_size_ff)
      else $error("payload count outside the chunk");
`endif

endmodule

FILE: rtl/http_chunked_body_decoder_top.sv
// Pipeline: a byte transferred in is held in the input register, decoded by the parser
// and captured in the result register, which drives the result ports.
// Throughput: one byte per cycle while the result channel does not stall; the single-pass
// parser between the input register and the result register keeps up with every cycle.
// Reset: synchronous and active high; it selects plain mode, clears both
// stages and leaves the parser waiting for a chunk size.
module http_chunked_body_decoder_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_payload_byte,
   output logic                            rsp_payload_valid,
   output logic                            rsp_message_done,
   output logic                            rsp_framing_error,
   output logic [hcbd_pkg::TOTAL_BITS-1:0] rsp_body_length,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_chunked_mode
);
   import hcbd_pkg::*;

   logic       chunked_mode_ff;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type res;
   logic       advance;
   logic       req_fire;

   // The mode register is always ready for a transfer.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunked_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         chunked_mode_ff <= csr_chunked_mode;
      end
   end

   // The input stage moves on whenever the result register is free or being emptied.
   assign advance   = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_fire  = req_valid && !req_stall;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers of both stages.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_data_byte;
      end
      if (advance) begin
         out_ff <= res;
      end
   end

   hcbd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .chunked_mode (chunked_mode_ff),
      .data_byte    (in_byte_ff),
      .res          (res)
   );

   // Result channel.
   assign rsp_valid         = out_valid_ff;
   assign rsp_payload_byte  = out_ff.payload_byte;
   assign rsp_payload_valid = out_ff.payload_valid;
   assign rsp_message_done  = out_ff.message_done;
   assign rsp_framing_error = out_ff.framing_error;
   assign rsp_body_length   = out_ff.body_length;

endmodule

FILE: dv/tb_http_chunked_body_decoder_top.sv
`timescale 1ns / 100ps

module tb_http_chunked_body_decoder_top;
   import hcbd_pkg::*;

   localparam int CLK_PERIOD      = 10;
   localparam int RESET_CYCLES    = 12;
   localparam int DRAIN_CYCLES    = 6;
   localparam int TIMEOUT_CYCLES  = 400000;
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 105;
   localparam int HOLD_PHASE      = 6;
   localparam int HOLD_CYCLES     = 300;
   localparam int NOISE_PCT       = 2;
   localparam int MAX_REPORTS     = 40;
   localparam logic [7:0] CHAR_SEMI = 8'h3B;

   // Where a directed row takes its expected result from.
   typedef enum logic [1:0] {
      WANT_MODEL,
      WANT_PAYLOAD,
      WANT_ERROR,
      WANT_DONE
   } want_kind_type;

   // Parser phases of the chunked framing.
   typedef enum logic [2:0] {
      SIZE_DIGITS,
      SIZE_LF,
      CHUNK_DATA,
      DATA_CR,
      DATA_LF
   } parse_phase_type;

   typedef struct packed {
      logic          set_mode;
      logic          mode;
      logic [7:0]    data;
      want_kind_type want_kind;
      logic [31:0]   want_len;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 26;

   // Directed bytes: plain pass-through, an empty size, a two byte chunk with a
   // leading zero and CR as data, a mode flip mid-message, the closing zero
   // chunk, an extension byte and a size that overflows on its ninth digit.
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{1'b0, 1'b0, 8'h00,            WANT_PAYLOAD, 32'd0},
      '{1'b1, 1'b1, CHAR_CR,          WANT_ERROR,   32'd0},
      '{1'b0, 1'b0, CHAR_0,           WANT_MODEL,   32'd0},
      '{1'b0, 1'b0, CHAR_0 + 8'd2,    WANT_MODEL,   32'd0},
      '{1'b0, 1'b0, CHAR_CR,          WANT_MODEL,   32'd0},
      '{1'b0, 1'b0, CHAR_LF,          WANT_MODEL,   32'd0},
      '{1'b0, 1'b0, 8'hFF,            WANT_PAYLOAD, 32'd0},
      '{1'b0, 1'b0, CHAR_CR,          WANT_PAYLOAD, 32'd0},
      '{1'b0, 1'b0, CHAR_CR,          WANT_MODEL,   32'd0},
      '{1'b0, 1'b0, CHAR_LF,          WANT_MODEL,   32'd0},
      '{1'b1, 1'b0, 8'h7E,            WANT_PAYLOAD, 32'd0},
      '{1'b1, 1'b1, CHAR_0,           WANT_MODEL,   32'd0},
      '{1'b0, 1'b0, CHAR_CR,          WANT_MODEL,   32'd0},
      '{1'b0, 1'b0, CHAR_LF,          WANT_MODEL,   32'd0},
      '{1'b0, 1'b0, CHAR_CR,          WANT_MODEL,   32'd0},
      '{1'b0, 1'b0, CHAR_LF,          WANT_DONE,    32'd2},
      '{1'b0, 1'b0, CHAR_SEMI,        WANT_ERROR,   32'd0},
      '{1'b0, 1'b0, CHAR_LO_F,        WANT_MODEL,   32'd0},
      '{1'b0, 1'b0, CHAR_UP_F,        WANT_MODEL,   32'd0},
      '{1'b0, 1'b0, CHAR_LO_F,        WANT_MODEL,   32'd0},
      '{1'b0, 1'b0, CHAR_UP_F,        WANT_MODEL,   32'd0},
      '{1'b0, 1'b0, CHAR_LO_F,        WANT_MODEL,   32'd0},
      '{1'b0, 1'b0, CHAR_UP_F,        WANT_MODEL,   32'd0},
      '{1'b0, 1'b0, CHAR_LO_F,        WANT_MODEL,   32'd0},
      '{1'b0, 1'b0, CHAR_UP_F,        WANT_MODEL,   32'd0},
      '{1'b0, 1'b0, CHAR_0,           WANT_ERROR,   32'd0}
   };

   logic                  clock;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_data_byte    = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic [7:0]            rsp_payload_byte;
   logic                  rsp_payload_valid;
   logic                  rsp_message_done;
   logic                  rsp_framing_error;
   logic [TOTAL_BITS-1:0] rsp_body_length;
   logic                  csr_valid        = 1'b0;
   logic                  csr_ready;
   logic                  csr_chunked_mode = 1'b0;

   // Predicted decoder state and configuration.
   logic                   mode_q;
   parse_phase_type        ph;
   logic [LENGTH_BITS-1:0] size_acc;
   logic [LENGTH_BITS-1:0] data_count;
   logic [TOTAL_BITS-1:0]  total_acc;
   logic [3:0]             digit_cnt;

   result_type pending_results [$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_req      = 0;
   int hold_taken    = 0;
   int unsigned hold_left = 0;

   int fail_count   = 0;
   int bytes_in     = 0;
   int results_seen = 0;
   int payload_seen = 0;
   int done_seen    = 0;
   int error_seen   = 0;
   int mode_writes  = 0;

   http_chunked_body_decoder_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_valid (rsp_payload_valid),
      .rsp_message_done  (rsp_message_done),
      .rsp_framing_error (rsp_framing_error),
      .rsp_body_length   (rsp_body_length),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_chunked_mode  (csr_chunked_mode)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Hard stop in case the handshakes hang.
   initial begin
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   // Returns the nibble value of a hex character, with bit 4 set for any other byte.
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [7:0] t;
      if (b >= CHAR_0 && b <= CHAR_9) begin
         return {1'b0, b[3:0]};
      end
      if (b >= CHAR_LO_A && b <= CHAR_LO_F) begin
         t = b - CHAR_LO_A + {4'd0, HEX_TEN};
         return {1'b0, t[3:0]};
      end
      if (b >= CHAR_UP_A && b <= CHAR_UP_F) begin
         t = b - CHAR_UP_A + {4'd0, HEX_TEN};
         return {1'b0, t[3:0]};
      end
      return 5'h10;
   endfunction

   // Hex character for a nibble, letters in either case.
   function automatic logic [7:0] hex_char(input logic [3:0] d);
      if (d < HEX_TEN) begin
         return CHAR_0 + {4'd0, d};
      end
      return ($urandom_range(0, 1) ? CHAR_UP_A : CHAR_LO_A) + {4'd0, d - HEX_TEN};
   endfunction

   // Done and framing errors put the whole chunked state back to its reset values.
   function automatic void clear_parser();
      ph         = SIZE_DIGITS;
      size_acc   = '0;
      data_count = '0;
      total_acc  = '0;
      digit_cnt  = '0;
   endfunction

   // Predicts the result of one byte and advances the predicted state.
   function automatic result_type decode_byte(input logic [7:0] b);
      result_type      r;
      logic [4:0]      nib;
      logic            bad;
      logic [SUM_BITS-1:0] sum;
      r   = '0;
      bad = 1'b0;
      nib = hex_value(b);
      if (!mode_q) begin
         r.payload_byte  = b;
         r.payload_valid = 1'b1;
      end else begin
         case (ph)
            SIZE_DIGITS: begin
               if (!nib[4]) begin
                  // A digit that would shift a set bit out of the size is an error.
                  if (size_acc[LENGTH_BITS-1 -: 4] != 4'd0) begin
                     bad = 1'b1;
                  end else begin
                     size_acc = {size_acc[LENGTH_BITS-5:0], nib[3:0]};
                     if (digit_cnt != 4'd15) digit_cnt = digit_cnt + 4'd1;
                  end
               end else if (b == CHAR_CR && digit_cnt != 4'd0) begin
                  sum = SUM_BITS'(total_acc) + SUM_BITS'(size_acc);
                  total_acc = (sum > SUM_BITS'({TOTAL_BITS{1'b1}})) ? '1
                                                                    : sum[TOTAL_BITS-1:0];
                  ph = SIZE_LF;
               end else begin
                  bad = 1'b1;
               end
            end
            SIZE_LF: begin
               if (b == CHAR_LF) begin
                  data_count = '0;
                  ph = (size_acc == '0) ? DATA_CR : CHUNK_DATA;
               end else begin
                  bad = 1'b1;
               end
            end
            CHUNK_DATA: begin
               r.payload_byte  = b;
               r.payload_valid = 1'b1;
               data_count = data_count + LENGTH_BITS'(1);
               if (data_count >= size_acc) ph = DATA_CR;
            end
            DATA_CR: begin
               if (b == CHAR_CR) ph = DATA_LF;
               else bad = 1'b1;
            end
            DATA_LF: begin
               if (b != CHAR_LF) begin
                  bad = 1'b1;
               end else if (size_acc != '0) begin
                  size_acc   = '0;
                  data_count = '0;
                  digit_cnt  = '0;
                  ph         = SIZE_DIGITS;
               end else begin
                  r.message_done = 1'b1;
                  r.body_length  = total_acc;
                  clear_parser();
               end
            end
            default: bad = 1'b1;
         endcase
         if (bad) begin
            r.framing_error = 1'b1;
            clear_parser();
         end
      end
      return r;
   endfunction

   // Picks the next random byte from the predicted state: mostly well-formed
   // framing with small chunk sizes, random data, and a little noise.
   function automatic logic [7:0] pick_byte();
      logic [7:0] b;
      logic [4:0] nib;
      int         roll;
      roll = $urandom_range(0, 99);
      b    = 8'($urandom_range(0, 255));
      nib  = hex_value(b);
      if (!mode_q || ph == CHUNK_DATA) return b;
      if (roll < NOISE_PCT) begin
         // Noise digits must not grow a size beyond 255 bytes.
         if (!nib[4] && size_acc >= 16) b = CHAR_SEMI;
         return b;
      end
      case (ph)
         SIZE_DIGITS: begin
            if (size_acc >= 16) b = CHAR_CR;
            else if (digit_cnt == 4'd0)
               b = (roll < 35) ? CHAR_0 : hex_char(4'($urandom_range(1, 15)));
            else if (size_acc == '0)
               b = (roll < 75) ? CHAR_CR : hex_char(4'($urandom_range(0, 15)));
            else
               b = (roll < 92) ? CHAR_CR : hex_char(4'($urandom_range(0, 15)));
         end
         DATA_CR: b = CHAR_CR;
         default: b = CHAR_LF;
      endcase
      return b;
   endfunction

   // Offers one byte, waits for the transfer and queues its expected result.
   task automatic send_byte(input logic [7:0] b, input want_kind_type want_kind,
                            input logic [31:0] want_len);
      result_type r;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      r = decode_byte(b);
      case (want_kind)
         WANT_PAYLOAD: begin
            r = '0;
            r.payload_byte  = b;
            r.payload_valid = 1'b1;
         end
         WANT_ERROR: begin
            r = '0;
            r.framing_error = 1'b1;
         end
         WANT_DONE: begin
            r = '0;
            r.message_done = 1'b1;
            r.body_length  = want_len;
         end
         default: ;
      endcase
      pending_results.push_back(r);
      bytes_in++;
   endtask

   // Stops offering and waits until every expected result has been seen.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes the mode register; only called with the decoder idle.
   task automatic write_mode(input logic m);
      csr_valid        <= 1'b1;
      csr_chunked_mode <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mode_q = m;
      mode_writes++;
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      end
   endtask

   // Receiver stall pattern, with a long hold-off counted here when requested.
   always @(posedge clock) begin
      if (hold_req != hold_taken) begin
         hold_left  = HOLD_CYCLES;
         hold_taken = hold_req;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   // Compares every result transfer with the oldest expectation.
   always @(posedge clock) begin : result_monitor
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         payload_seen += int'(rsp_payload_valid);
         done_seen    += int'(rsp_message_done);
         error_seen   += int'(rsp_framing_error);
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
               $display("%0t: unexpected result, expected none, actual payload %0h",
                        $time, rsp_payload_byte);
            end
         end else begin
            want = pending_results.pop_front();
            check_field("payload_byte", 64'(want.payload_byte), 64'(rsp_payload_byte));
            check_field("payload_valid", 64'(want.payload_valid), 64'(rsp_payload_valid));
            check_field("message_done", 64'(want.message_done), 64'(rsp_message_done));
            check_field("framing_error", 64'(want.framing_error),
                        64'(rsp_framing_error));
            check_field("body_length", 64'(want.body_length), 64'(rsp_body_length));
         end
      end
   end

   // Reset, directed table, randomized phases and the verdict.
   initial begin : stimulus
      int seg;
      int i;
      mode_q = 1'b0;
      clear_parser();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < DIRECTED_ROWS; i++) begin
         if (DIRECTED[i].set_mode) begin
            drain_results();
            write_mode(DIRECTED[i].mode);
         end
         send_byte(DIRECTED[i].data, DIRECTED[i].want_kind, DIRECTED[i].want_len);
      end

      // Each phase waits for all results, rewrites the mode, then picks an idling mix.
      for (seg = 0; seg < RANDOM_PHASES; seg++) begin
         drain_results();
         write_mode((seg % 5) != 3);
         case (seg % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 69; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 69; end
            default: begin send_idle_pct = 18; rsp_stall_pct = 18; end
         endcase
         if (seg == HOLD_PHASE) begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
            hold_req++;
         end
         for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            send_byte(pick_byte(), WANT_MODEL, 32'd0);
         end
      end

      drain_results();
      $display("Sent %0d bytes and checked %0d results: %0d payload, %0d done, %0d errors.",
               bytes_in, results_seen, payload_seen, done_seen, error_seen);
      $display("Mode register written %0d times over %0d randomized phases.",
               mode_writes, RANDOM_PHASES);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
